// ===== rtl/sliding_window_median_defines.svh =====
// assertion macros shared by the sliding window median rtl
// no dependencies
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// next-cycle implication
`define SWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`endif

// ===== rtl/swm_pkg.sv =====
// shared types for the sliding window median filter
// no dependencies
`timescale 1ns / 1ps

package swm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_REMOVE,
    CMD_ADD,
    CMD_SELECT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic start;
  } swm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic full;
  } swm_stat_t;

endpackage

// ===== rtl/swm_datapath.sv =====
// counting tree, delay line and sequencing datapath for the median filter
// depends on swm_pkg
`timescale 1ns / 1ps
`include "sliding_window_median_defines.svh"

module swm_datapath #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_WINDOW = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swm_pkg::swm_ctrl_t        ctrl_i,
  input  logic [VALUE_BITS-1:0]     sample_i,
  input  logic [10:0]               cfg_i,
  output swm_pkg::swm_stat_t        stat_o,
  output logic [VALUE_BITS-1:0]     median_o
);

  localparam int NodeW  = VALUE_BITS + 1;
  localparam int Nodes  = 2 ** NodeW;
  localparam int SlotW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CntW   = $clog2(MAX_WINDOW + 1);
  localparam int LvlW   = $clog2(NodeW + 1);

  typedef enum logic [2:0] {
    P_IDLE, P_CLR, P_RD, P_WAIT, P_WR, P_SRD, P_SWAIT, P_SDEC
  } ph_e;

  logic [CntW-1:0]      count_mem [Nodes];
  logic [VALUE_BITS-1:0] line_mem [MAX_WINDOW];

  ph_e                   ph_q;
  swm_pkg::cmd_e         op_q;
  logic [NodeW-1:0]      node_q;
  logic [LvlW-1:0]       lvl_q;
  logic [CntW-1:0]       rank_q;
  logic [CntW-1:0]       rd_q;
  logic [VALUE_BITS-1:0] old_q, new_q, med_q;
  logic [SlotW-1:0]      slot_q;
  logic [CntW-1:0]       fill_q;
  logic [CntW-1:0]       win;
  logic [NodeW-1:0]      rd_addr, wr_addr;
  logic                  wr_en;
  logic [CntW-1:0]       wr_data;
  logic                  clr_go;

  // effective window: zero -> one, saturate at max
  always_comb begin
    if (cfg_i == '0) begin
      win = CntW'(1);
    end else if (32'(cfg_i) > 32'(MAX_WINDOW)) begin
      win = CntW'(MAX_WINDOW);
    end else begin
      win = CntW'(cfg_i);
    end
  end

  assign rd_addr = node_q;
  assign wr_addr = node_q;
  assign wr_en   = (ph_q == P_CLR) || (ph_q == P_WR);
  assign wr_data = (ph_q == P_CLR) ? '0 :
                   (op_q == swm_pkg::CMD_REMOVE) ? rd_q - CntW'(1) : rd_q + CntW'(1);
  assign clr_go  = (ph_q == P_IDLE) && ctrl_i.start && (ctrl_i.cmd == swm_pkg::CMD_CLEAR);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      count_mem[wr_addr] <= wr_data;
    end
    rd_q <= count_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && ctrl_i.cmd == swm_pkg::CMD_LOAD) begin
      if (fill_q == win) begin
        old_q <= line_mem[slot_q];
        line_mem[slot_q] <= sample_i;
      end else begin
        line_mem[fill_q[SlotW-1:0]] <= sample_i;
      end
      new_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= P_CLR;
      op_q   <= swm_pkg::CMD_CLEAR;
      node_q <= '0;
      lvl_q  <= '0;
      rank_q <= '0;
      med_q  <= '0;
      slot_q <= '0;
      fill_q <= '0;
    end else begin
      case (ph_q)
        P_IDLE: begin
          if (ctrl_i.start) begin
            op_q <= ctrl_i.cmd;
            case (ctrl_i.cmd)
              swm_pkg::CMD_CLEAR: begin
                node_q <= '0;
                fill_q <= '0;
                slot_q <= '0;
                ph_q   <= P_CLR;
              end
              swm_pkg::CMD_LOAD: begin
                if (fill_q == win) begin
                  slot_q <= (CntW'(slot_q) + CntW'(1) == win) ? '0 : slot_q + SlotW'(1);
                end else begin
                  fill_q <= fill_q + CntW'(1);
                end
              end
              swm_pkg::CMD_REMOVE, swm_pkg::CMD_ADD: begin
                node_q <= {1'b1, (ctrl_i.cmd == swm_pkg::CMD_REMOVE) ? old_q : new_q};
                ph_q   <= P_RD;
              end
              swm_pkg::CMD_SELECT: begin
                node_q <= NodeW'(2);
                lvl_q  <= '0;
                rank_q <= CntW'((32'(win) + 32'd1) >> 1);
                ph_q   <= P_SRD;
              end
              default: ;
            endcase
          end
        end
        P_CLR: begin
          node_q <= node_q + NodeW'(1);
          if (node_q == NodeW'(Nodes - 1)) begin
            ph_q <= P_IDLE;
          end
        end
        P_RD:   ph_q <= P_WAIT;
        P_WAIT: ph_q <= P_WR;
        P_WR: begin
          if (node_q == NodeW'(1)) begin
            ph_q <= P_IDLE;
          end else begin
            node_q <= node_q >> 1;
            ph_q   <= P_RD;
          end
        end
        P_SRD:   ph_q <= P_SWAIT;
        P_SWAIT: ph_q <= P_SDEC;
        P_SDEC: begin
          // rd_q holds the left child count
          if (rank_q > rd_q) begin
            rank_q <= rank_q - rd_q;
          end
          if (32'(lvl_q) == VALUE_BITS - 1) begin
            med_q <= (rank_q <= rd_q) ? node_q[VALUE_BITS-1:0]
                                      : node_q[VALUE_BITS-1:0] | VALUE_BITS'(1);
            ph_q  <= P_IDLE;
          end else begin
            node_q <= ((rank_q <= rd_q) ? node_q : (node_q | NodeW'(1))) << 1;
            lvl_q  <= lvl_q + LvlW'(1);
            ph_q   <= P_SRD;
          end
        end
        default: ph_q <= P_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (ph_q != P_IDLE);
  assign stat_o.full = (fill_q == win);
  assign median_o    = med_q;

  `SWM_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= win)
  `SWM_ASSERT_NXT(a_clr_busy, clr_go, stat_o.busy)
  `SWM_ASSERT_IMP(a_sel_level, ph_q == P_SDEC, 32'(lvl_q) < VALUE_BITS)

endmodule

// ===== rtl/swm_ctrl.sv =====
// sequencing state machine for the median filter
// depends on swm_pkg
`timescale 1ns / 1ps
`include "sliding_window_median_defines.svh"

module swm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               cfg_we_o,
  input  swm_pkg::swm_stat_t stat_i,
  output swm_pkg::swm_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_REM, S_ADD, S_SEL, S_WAITSEL, S_OUT, S_WAITCLR
  } state_e;

  state_e state_q;
  logic   busy;

  assign busy        = stat_i.busy;
  assign in_ready_o  = (state_q == S_IDLE) && !busy;
  assign cfg_ready_o = (state_q == S_IDLE) && !busy && !in_valid_i;
  assign cfg_we_o    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    ctrl_o.start = 1'b0;
    ctrl_o.cmd   = swm_pkg::CMD_NONE;
    if (cfg_we_o) begin
      ctrl_o.start = 1'b1;
      ctrl_o.cmd   = swm_pkg::CMD_CLEAR;
    end else if (in_valid_i && in_ready_o) begin
      ctrl_o.start = 1'b1;
      ctrl_o.cmd   = swm_pkg::CMD_LOAD;
    end else if (!busy) begin
      case (state_q)
        S_REM: begin
          ctrl_o.start = 1'b1;
          ctrl_o.cmd   = swm_pkg::CMD_REMOVE;
        end
        S_ADD: begin
          ctrl_o.start = 1'b1;
          ctrl_o.cmd   = swm_pkg::CMD_ADD;
        end
        S_SEL: begin
          ctrl_o.start = 1'b1;
          ctrl_o.cmd   = swm_pkg::CMD_SELECT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= stat_i.full ? S_REM : S_ADD;
          end
        end
        S_REM: if (!busy) state_q <= S_ADD;
        S_ADD: if (!busy) state_q <= S_SEL;
        S_SEL: begin
          // full flag is now the post-load value
          if (!busy) begin
            state_q <= stat_i.full ? S_WAITSEL : S_IDLE;
          end
        end
        S_WAITSEL: begin
          if (!busy) begin
            out_valid_o <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SWM_ASSERT_IMP(a_out_state, out_valid_o, state_q == S_OUT)
  `SWM_ASSERT_IMP(a_no_in_busy, in_ready_o, !busy && !out_valid_o)
  `SWM_ASSERT_NXT(a_cfg_idle, cfg_we_o, state_q == S_IDLE && stat_i.busy)

endmodule

// ===== rtl/sliding_window_median.sv =====
// sliding window running median filter, top level
// depends on swm_pkg, swm_ctrl, swm_datapath
//
//  channel   | dir | handshake               | word
//  s_axis    | in  | s_axis_tvalid / tready  | tdata[15:0] sample
//  m_axis    | out | m_axis_tvalid / tready  | tdata[15:0] median
//  cfg       | in  | cfg_valid / cfg_ready   | cfg_data[10:0] window_length
//
// with a full window each accepted word runs a removal, an addition and a median descent:
// removal and addition walk leaf to root, reading and writing each level in P_RD, P_WAIT
// and P_WR through the single count memory port, then the median descent takes P_SRD,
// P_SWAIT and P_SDEC a level; while the window fills there is no removal
// after reset and after every window_length write a clearing pass over all
// 2^(VALUE_BITS+1) count memory entries runs; no sample is taken meanwhile
// a stalled output holds the block; the next sample waits until the median is taken
`timescale 1ns / 1ps

module sliding_window_median #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_WINDOW = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] median
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data        // [10:0] window_length
);

  swm_pkg::swm_ctrl_t    ctrl;
  swm_pkg::swm_stat_t    stat;
  logic                  cfg_we;
  logic [10:0]           win_q;
  logic [VALUE_BITS-1:0] med;

  // window length register, reset to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 11'd1;
    end else if (cfg_we) begin
      win_q <= cfg_data;
    end
  end

  swm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cfg_we_o    (cfg_we),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  swm_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (VALUE_BITS'(s_axis_tdata)),
    .cfg_i    (win_q),
    .stat_o   (stat),
    .median_o (med)
  );

  assign m_axis_tdata = 16'(med);

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the sliding window median filter
// depends on the sliding_window_median top level; drives the stream and cfg ports
// and checks every median word against a sorted-window prediction
`timescale 1ns / 1ps

// keeps a copy of the window and a queue of expected medians
class median_scoreboard;
  logic [15:0] window_q[$];
  logic [15:0] median_q[$];
  int unsigned win_len;
  int unsigned mismatches;

  function new();
    win_len     = 1;
    mismatches  = 0;
  endfunction

  // window length write: zero acts as one, large values saturate, window empties
  function void set_window(logic [10:0] len);
    win_len = (len == 0) ? 1 : ((len > 1024) ? 1024 : len);
    window_q.delete();
  endfunction

  // accepted sample: slide the window and predict the lower median once full
  function void note_sample(logic [15:0] smp);
    logic [15:0] sorted_q[$];
    window_q.push_back(smp);
    if (window_q.size() > win_len) void'(window_q.pop_front());
    if (window_q.size() == win_len) begin
      sorted_q = window_q;
      sorted_q.sort();
      median_q.push_back(sorted_q[(win_len + 1) / 2 - 1]);
    end
  endfunction

  function void fail(string what, logic [15:0] exp_v, logic [15:0] act_v);
    if (mismatches < 10)
      $display("%s: expected %h actual %h", what, exp_v, act_v);
    mismatches++;
  endfunction

  function void check_median(logic [15:0] med);
    logic [15:0] exp_v;
    if (median_q.size() == 0) begin
      fail("median word with none expected", 16'h0, med);
      return;
    end
    exp_v = median_q.pop_front();
    if (med !== exp_v) fail("median mismatch", exp_v, med);
  endfunction

  function int unsigned outstanding();
    return median_q.size();
  endfunction
endclass

module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;    // [15:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] median
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;        // [10:0] window_length

  localparam int IDLE_LIMIT  = 600000;  // clearing pass alone covers 131072 count entries
  localparam int SETTLE_CYC  = 400;     // lets the last sample finish inside the block
  localparam int HOLD_CYC    = 3000;    // long receiver hold-off

  median_scoreboard sb = new();
  int unsigned medians_taken = 0;
  int unsigned idle_cycles   = 0;
  logic [15:0] last_sample   = '0;

  sliding_window_median u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(11);
      if (medians_taken == 150) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_median(m_axis_tdata);
      medians_taken++;
    end
  end

  // one sample word; valid stays high across back-to-back words
  task automatic send_sample(logic [15:0] smp);
    int unsigned gap;
    gap = $urandom_range(11);
    if (($urandom_range(3) == 0)) gap = 0;  // stretches with no idling
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(smp);
    last_sample = smp;
  endtask

  // drain all medians, let the datapath settle, then rewrite the window length
  task automatic write_window(logic [10:0] len);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_window(len);
  endtask

  // mix of full-range, clustered, extreme and repeated values
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(5))
      0, 1: return 16'($urandom);
      2:    return 16'h8000 + 16'($urandom_range(15)) - 16'd8;
      3:    return $urandom_range(1) ? 16'hffff : 16'h0000;
      4:    return last_sample;
      default: return 16'($urandom_range(40));
    endcase
  endfunction

  task automatic random_run(int unsigned n);
    repeat (n) send_sample(pick_sample());
  endtask

  initial begin
    logic [15:0] directed [12] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff,
                                   16'haaaa, 16'h5555, 16'hffff, 16'hffff, 16'h0000,
                                   16'h1234, 16'hfffe};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window of one: each median is the sample itself
    foreach (directed[i]) send_sample(directed[i]);

    // all ones saturates to the largest window
    write_window(11'h7ff);
    random_run(1090);

    // zero acts as a window of one
    write_window(11'h000);
    random_run(60);

    // small even window, with the long receiver hold-off in here
    write_window(11'd6);
    foreach (directed[i]) send_sample(directed[i]);
    random_run(150);

    // small odd window
    write_window(11'd5);
    random_run(120);

    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
